@@ rtl/round_robin_tick_scheduler_unit_defines.svh @@
// assertion macros for the round-robin tick scheduler checker
// expects clk and arst_n to be visible where a macro is used
`ifndef ROUND_ROBIN_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrts check failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrts check failed");

`endif

@@ rtl/rrts_pkg.sv @@
`timescale 1ns / 1ps
// shared types, sizes and helpers for the round-robin tick scheduler
// no dependencies
package rrts_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int BURST_BITS = 16;
	localparam int TIME_BITS  = 32;
	localparam int SLICE_BITS = 8;
	localparam int ID_BITS    = $clog2(MAX_TASKS);
	localparam int CNT_BITS   = $clog2(MAX_TASKS + 1);

	localparam logic [SLICE_BITS-1:0] QUANTUM_RESET = SLICE_BITS'(4);

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_TICK   = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_EXEC
	} state_e;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  task_id;
		logic [15:0] burst_length;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  running_id;
		logic        idle;
		logic        finished;
		logic        preempted;
		logic [31:0] completion_time;
		logic        error;
	} out_word_t;

	typedef struct packed {
		logic               push;
		logic [ID_BITS-1:0] push_id;
		logic               pop;
	} q_cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] count;
		logic [ID_BITS-1:0]  head_id;
	} q_stat_t;

	function automatic logic [ID_BITS-1:0] next_slot(input logic [ID_BITS-1:0] p);
		logic [ID_BITS-1:0] r;
		if (32'(p) >= MAX_TASKS - 1) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

@@ rtl/rrts_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read memory with registered read data
// no dependencies
module rrts_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rrts_queue.sv @@
`timescale 1ns / 1ps
// ready queue: circular fifo of task ids with head, tail and fill count
// depends on rrts_pkg and rrts_ram
module rrts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  rrts_pkg::q_cmd_t  cmd,
	output rrts_pkg::q_stat_t stat
);
	import rrts_pkg::*;

	logic [ID_BITS-1:0]  head_q;
	logic [ID_BITS-1:0]  tail_q;
	logic [CNT_BITS-1:0] count_q;
	logic [ID_BITS-1:0]  rd_id;

	// head entry is read on every cycle, so its id reaches stat through the registered read port
	rrts_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(MAX_TASKS)
	) u_mem (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(tail_q),
		.wdata(cmd.push_id),
		.raddr(head_q),
		.rdata(rd_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= next_slot(tail_q);
			end
			if (cmd.pop) begin
				head_q <= next_slot(head_q);
			end
			count_q <= count_q + CNT_BITS'(cmd.push) - CNT_BITS'(cmd.pop);
		end
	end

	assign stat.count   = count_q;
	assign stat.head_id = rd_id;

endmodule

@@ rtl/rrts_ctrl.sv @@
`timescale 1ns / 1ps
// scheduler sequencer: running task, slice, time counter and result word
// depends on rrts_pkg
module rrts_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  rrts_pkg::in_word_t               cmd,
	output logic                             done,
	output rrts_pkg::out_word_t              result,
	input  logic                             quantum_we,
	input  logic [7:0]                       quantum_wdata,
	output rrts_pkg::q_cmd_t                 q_cmd,
	input  rrts_pkg::q_stat_t                q_stat,
	output logic                             rem_we,
	output logic [rrts_pkg::ID_BITS-1:0]     rem_waddr,
	output logic [rrts_pkg::BURST_BITS-1:0]  rem_wdata,
	output logic [rrts_pkg::ID_BITS-1:0]     rem_raddr,
	input  logic [rrts_pkg::BURST_BITS-1:0]  rem_rdata
);
	import rrts_pkg::*;

	state_e                state_q, state_d;
	logic [ID_BITS-1:0]    cur_task_q;
	logic                  cur_valid_q;
	logic [SLICE_BITS-1:0] slice_q;
	logic [SLICE_BITS-1:0] quantum_q;
	logic                  pend_q;
	logic                  fwd_q;
	logic [TIME_BITS-1:0]  time_q;
	logic                  done_q;
	out_word_t             result_q;

	logic                  accept;
	logic                  is_tick;
	logic [CNT_BITS:0]     occupied;
	logic                  arr_ok;
	logic                  need_pop;
	logic [BURST_BITS-1:0] burst;
	logic [ID_BITS-1:0]    pop_id;
	logic [BURST_BITS-1:0] rem_new;
	logic [SLICE_BITS-1:0] slice_new;
	logic                  fin;
	logic                  pre;
	logic                  done_d;
	out_word_t             result_d;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_tick = (cmd.opcode == OP_TICK);
	assign burst   = cmd.burst_length[BURST_BITS-1:0];

	// the running task and a pending requeue both hold a slot
	assign occupied = (CNT_BITS+1)'(q_stat.count) + (CNT_BITS+1)'(cur_valid_q)
		+ (CNT_BITS+1)'(pend_q);
	assign arr_ok = (burst != '0) && (32'(cmd.task_id) < MAX_TASKS)
		&& (32'(occupied) < MAX_TASKS);

	// a pending requeue implies no running task
	assign need_pop = !cur_valid_q && ((q_stat.count != '0) || pend_q);

	// empty queue at pop time means the head is the requeued task itself
	assign pop_id = fwd_q ? cur_task_q : q_stat.head_id;

	assign rem_new   = (rem_rdata == '0) ? '0 : rem_rdata - 1'b1;
	assign slice_new = slice_q - 1'b1;
	assign fin       = (rem_new == '0);
	assign pre       = !fin && (slice_new == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_tick) begin
					if (need_pop) begin
						state_d = ST_POP;
					end else if (cur_valid_q) begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_POP:  state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_cmd.push    = accept && (is_tick ? pend_q : arr_ok);
		q_cmd.push_id = is_tick ? cur_task_q : cmd.task_id[ID_BITS-1:0];
		q_cmd.pop     = accept && is_tick && need_pop;
		rem_we        = 1'b0;
		rem_waddr     = cmd.task_id[ID_BITS-1:0];
		rem_wdata     = burst;
		rem_raddr     = cur_task_q;
		done_d        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rem_we = accept && !is_tick && arr_ok;
				// arrivals and idle ticks answer at once
				done_d = accept && !(is_tick && (need_pop || cur_valid_q));
			end
			ST_POP: begin
				rem_raddr = pop_id;
			end
			ST_EXEC: begin
				rem_we    = 1'b1;
				rem_waddr = cur_task_q;
				rem_wdata = rem_new;
				done_d    = 1'b1;
			end
			default: begin
				rem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		result_d = '0;
		if (state_q == ST_EXEC) begin
			result_d.running_id      = 4'(cur_task_q);
			result_d.finished        = fin;
			result_d.preempted       = pre;
			result_d.completion_time = 32'(time_q);
		end else if (is_tick) begin
			result_d.idle            = 1'b1;
			result_d.completion_time = 32'(time_q + 1'b1);
		end else begin
			result_d.error = !arr_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (quantum_we) begin
			quantum_q <= quantum_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_task_q  <= '0;
			cur_valid_q <= 1'b0;
			slice_q     <= '0;
			pend_q      <= 1'b0;
			fwd_q       <= 1'b0;
			time_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_tick) begin
						pend_q <= 1'b0;
						time_q <= time_q + 1'b1;
						if (need_pop) begin
							cur_valid_q <= 1'b1;
							slice_q     <= quantum_q;
							fwd_q       <= (q_stat.count == '0);
						end
					end
				end
				ST_POP: begin
					cur_task_q <= pop_id;
				end
				ST_EXEC: begin
					slice_q <= slice_new;
					if (fin || pre) begin
						cur_valid_q <= 1'b0;
					end
					if (pre) begin
						pend_q <= 1'b1;
					end
				end
				default: begin
					fwd_q <= 1'b0;
				end
			endcase
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if ((state_q == ST_EXEC) || accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/round_robin_tick_scheduler_unit.sv @@
`timescale 1ns / 1ps
// top level of the round-robin tick scheduler
// depends on rrts_pkg, rrts_ram, rrts_queue and rrts_ctrl
//
//   channel  | signals                       | handshake
//   ---------+-------------------------------+------------------------------
//   command  | cmd (opcode, task_id, burst)  | taken when start && !busy
//   result   | result (id, flags, time, err) | done high for one cycle
//   config   | quantum_wdata                 | written when quantum_we
//
// an arrive word and a tick with nothing to run answer straight from idle; a
// tick that continues the running task goes through exec, and a tick that pops
// the queue through pop and then exec: the popped id comes out of the queue
// memory (or is the requeued task itself when the queue was empty) and then
// addresses the remaining-burst memory. done and the result word are registered.
// reset empties the queue and stops any task; the result side cannot stall.
module round_robin_tick_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rrts_pkg::in_word_t  cmd,
	output logic                done,
	output rrts_pkg::out_word_t result,
	input  logic                quantum_we,
	input  logic [7:0]          quantum_wdata
);
	import rrts_pkg::*;

	q_cmd_t                q_cmd;
	q_stat_t               q_stat;
	logic                  rem_we;
	logic [ID_BITS-1:0]    rem_waddr;
	logic [BURST_BITS-1:0] rem_wdata;
	logic [ID_BITS-1:0]    rem_raddr;
	logic [BURST_BITS-1:0] rem_rdata;

	rrts_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (q_cmd),
		.stat  (q_stat)
	);

	// remaining burst per task id
	rrts_ram #(
		.WIDTH(BURST_BITS),
		.DEPTH(MAX_TASKS)
	) u_rem (
		.clk  (clk),
		.we   (rem_we),
		.waddr(rem_waddr),
		.wdata(rem_wdata),
		.raddr(rem_raddr),
		.rdata(rem_rdata)
	);

	rrts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.done         (done),
		.result       (result),
		.quantum_we   (quantum_we),
		.quantum_wdata(quantum_wdata),
		.q_cmd        (q_cmd),
		.q_stat       (q_stat),
		.rem_we       (rem_we),
		.rem_waddr    (rem_waddr),
		.rem_wdata    (rem_wdata),
		.rem_raddr    (rem_raddr),
		.rem_rdata    (rem_rdata)
	);

endmodule

@@ rtl/rrts_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the round-robin tick scheduler, bound to the top level
// depends on rrts_pkg and round_robin_tick_scheduler_unit_defines.svh
`include "round_robin_tick_scheduler_unit_defines.svh"

module rrts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input rrts_pkg::in_word_t  cmd,
	input logic                done,
	input rrts_pkg::out_word_t result,
	input logic                quantum_we,
	input logic [7:0]          quantum_wdata
);
	import rrts_pkg::*;

	logic unused_cfg;
	assign unused_cfg = quantum_we ^ (^quantum_wdata);

	// an arrive word answers in the very next cycle
	`RRTS_ASSERT_NEXT(a_arrive_answers, start && !busy && (cmd.opcode == OP_ARRIVE), done && !busy)

	// a tick either answers at once or keeps the block busy
	`RRTS_ASSERT_NEXT(a_tick_progress, start && !busy && (cmd.opcode == OP_TICK), done || busy)

	// a rejected arrival reports nothing about running tasks
	`RRTS_ASSERT_NOW(a_error_clean, done && result.error, !result.idle && !result.finished && !result.preempted && (result.running_id == '0) && (result.completion_time == '0))

	// at most one outcome flag per word
	`RRTS_ASSERT_NOW(a_flags_excl, done, $onehot0({result.idle, result.finished, result.preempted, result.error}))

endmodule

bind round_robin_tick_scheduler_unit rrts_checker u_rrts_checker (.*);
